// ----- hw/rtl/fprvt_pkg.sv -----
// Shared types and constants of the flow pulse rate and volume tracker.
package fprvt_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    // command codes of an input request
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_IN_PULSE  = 2'd1;
    localparam logic [1:0] CMD_OUT_PULSE = 2'd2;
    localparam logic [1:0] CMD_LOAD      = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CAL  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADVANCE = 8'd3;

    localparam logic [15:0] WINDOW_RST  = 16'd1000;
    localparam logic [15:0] CAL_RST     = 16'd1920;

    // rate arithmetic, Q8.8
    localparam logic [9:0]  RATE_SCALE    = 10'd1000;
    localparam logic [15:0] RATE_ONE      = 16'd256;
    localparam logic [15:0] RATE_LOW_MAX  = 16'd6;    // rate * 40 < 256
    localparam logic [15:0] RATE_SAT      = 16'hFFFF;

    // volume step = floor(rate * 50 / 3), the /3 done by reciprocal
    localparam int          STEP_X_W   = 22;
    localparam int          STEP_W     = 21;
    localparam logic [5:0]  VOL_GAIN   = 6'd50;
    localparam logic [22:0] VOL_RECIP  = 23'd5592406;  // ceil(2^24 / 3)
    localparam int          VOL_SHIFT  = 24;
    localparam int          STEP_P_W   = STEP_X_W + 23;

    // divider: 16 quotient bits, 32-bit divisor
    localparam int DIV_Q_W = 16;
    localparam int DIV_D_W = 32;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        menu_idle;
        logic [31:0] volume_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] in_rate;
        logic [15:0] out_rate;
        logic [31:0] volume;
        logic        close_fill_valve;
        logic        advance_regimen;
        logic        save_volume;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic [DIV_D_W-1:0] rem_init;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hw/rtl/flow_pulse_rate_volume_tracker_core.sv -----
// Flow pulse rate and volume tracker: top level with sequencer and state.
// Pulse, load and non-evaluating tick requests are handled in the idle state.
// An evaluating tick runs, per channel, a multiply, a check and a hand-over state, with the
// shared divider between check and hand-over when it runs, then the volume step per channel,
// and a finish state that waits for a free result slot. One request at a time.
// Reset (aresetn low, synchronous) clears counts, volume, flags and restores config.
module flow_pulse_rate_volume_tracker_core #(
    parameter int COUNT_WIDTH = fprvt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fprvt_pkg::in_item_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fprvt_pkg::out_item_t              m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fprvt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data
);
    import fprvt_pkg::*;

    localparam int NUM_W = COUNT_WIDTH + 10;
    localparam int CMP_W = (NUM_W > DIV_D_W) ? NUM_W : DIV_D_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL    = 4'd1;
    localparam logic [3:0] ST_CHK    = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_NEXT   = 4'd4;
    localparam logic [3:0] ST_VMUL   = 4'd5;
    localparam logic [3:0] ST_VMUL2  = 4'd6;
    localparam logic [3:0] ST_VAPPLY = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic                   sel_reg, sel_next;
    logic                   idle_reg, idle_next;
    logic [15:0]            elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0] in_cnt_reg, in_cnt_next;
    logic [COUNT_WIDTH-1:0] out_cnt_reg, out_cnt_next;
    logic [31:0]            vol_reg, vol_next;
    logic                   in_act_reg, in_act_next;
    logic                   out_act_reg, out_act_next;
    logic [15:0]            window_reg, window_next;
    logic [15:0]            in_cal_reg, in_cal_next;
    logic [15:0]            out_cal_reg, out_cal_next;
    logic                   adv_en_reg, adv_en_next;
    logic                   m_valid_reg, m_valid_next;

    logic [DIV_D_W-1:0]     den_reg, den_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [15:0]            in_rate_reg, in_rate_next;
    logic [15:0]            out_rate_reg, out_rate_next;
    logic [STEP_X_W-1:0]    x_reg, x_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    out_item_t              m_data_reg, m_data_next;

    logic [15:0]            el_inc;
    logic [15:0]            cur_rate;
    logic [15:0]            cur_cal;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [15:0]            rate_val;
    logic                   rate_wr;
    logic [32:0]            vol_sum;
    logic [STEP_P_W-1:0]    step_prod;
    logic                   close_v;
    logic                   save_v;

    div_req_t div_req;
    div_rsp_t div_rsp;

    fprvt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cur_rate  = sel_reg ? out_rate_reg : in_rate_reg;
    assign cur_cal   = sel_reg ? out_cal_reg  : in_cal_reg;
    assign cur_cnt   = sel_reg ? out_cnt_reg  : in_cnt_reg;
    assign el_inc    = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign vol_sum   = {1'b0, vol_reg} + {{(33-STEP_W){1'b0}}, step_reg};
    assign step_prod = STEP_P_W'(x_reg) * STEP_P_W'(VOL_RECIP);
    assign close_v   = idle_reg && (in_rate_reg > RATE_ONE);
    assign save_v    = idle_reg && (in_act_reg || out_act_reg) &&
                       (in_rate_reg <= RATE_LOW_MAX) && (out_rate_reg <= RATE_LOW_MAX);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign div_req.start    = (state_reg == ST_CHK) && (den_reg != '0) &&
                              (CMP_W'(num_reg) < CMP_W'(den_reg));
    assign div_req.rem_init = DIV_D_W'(num_reg);
    assign div_req.divisor  = den_reg;

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        idle_next     = idle_reg;
        elapsed_next  = elapsed_reg;
        in_cnt_next   = in_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        vol_next      = vol_reg;
        in_act_next   = in_act_reg;
        out_act_next  = out_act_reg;
        window_next   = window_reg;
        in_cal_next   = in_cal_reg;
        out_cal_next  = out_cal_reg;
        adv_en_next   = adv_en_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        den_next      = den_reg;
        num_next      = num_reg;
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        x_next        = x_reg;
        step_next     = step_reg;
        m_data_next   = m_data_reg;
        rate_val      = '0;
        rate_wr       = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WINDOW:  window_next  = cfg_data;
                REG_IN_CAL:  in_cal_next  = cfg_data;
                REG_OUT_CAL: out_cal_next = cfg_data;
                REG_ADVANCE: adv_en_next  = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.cmd)
                        CMD_TICK: begin
                            elapsed_next = el_inc;
                            if (el_inc > window_reg) begin
                                idle_next  = s_data.menu_idle;
                                sel_next   = 1'b0;
                                state_next = ST_MUL;
                            end
                        end
                        CMD_IN_PULSE: begin
                            if (in_cnt_reg != COUNT_MAX) in_cnt_next = in_cnt_reg + 1'b1;
                        end
                        CMD_OUT_PULSE: begin
                            if (out_cnt_reg != COUNT_MAX) out_cnt_next = out_cnt_reg + 1'b1;
                        end
                        CMD_LOAD: begin
                            vol_next = s_data.volume_value;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                den_next   = {16'd0, elapsed_reg} * {16'd0, cur_cal};
                num_next   = NUM_W'(cur_cnt) * NUM_W'(RATE_SCALE);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // zero divisor only with zero calibration; quotient overflow
                // exactly when count*1000 >= divisor
                if (den_reg == '0) begin
                    rate_wr    = 1'b1;
                    rate_val   = (cur_cnt != '0) ? RATE_SAT : 16'd0;
                    state_next = ST_NEXT;
                end else if (CMP_W'(num_reg) >= CMP_W'(den_reg)) begin
                    rate_wr    = 1'b1;
                    rate_val   = RATE_SAT;
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    rate_wr    = 1'b1;
                    rate_val   = div_rsp.quotient;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                sel_next   = !sel_reg;
                state_next = sel_reg ? ST_VMUL : ST_MUL;
            end
            ST_VMUL: begin
                if (idle_reg && (cur_rate > RATE_ONE)) begin
                    x_next     = STEP_X_W'(cur_rate) * STEP_X_W'(VOL_GAIN);
                    state_next = ST_VMUL2;
                end else if (!sel_reg) begin
                    sel_next = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_VMUL2: begin
                step_next  = step_prod[VOL_SHIFT +: STEP_W];
                state_next = ST_VAPPLY;
            end
            ST_VAPPLY: begin
                if (!sel_reg) begin
                    vol_next    = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];
                    in_act_next = 1'b1;
                    sel_next    = 1'b1;
                    state_next  = ST_VMUL;
                end else begin
                    vol_next     = (vol_reg > 32'(step_reg)) ? vol_reg - 32'(step_reg) : 32'd0;
                    out_act_next = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.in_rate          = in_rate_reg;
                    m_data_next.out_rate         = out_rate_reg;
                    m_data_next.volume           = vol_reg;
                    m_data_next.close_fill_valve = close_v;
                    m_data_next.advance_regimen  = close_v && adv_en_reg;
                    m_data_next.save_volume      = save_v;
                    if (save_v) begin
                        in_act_next  = 1'b0;
                        out_act_next = 1'b0;
                    end
                    in_cnt_next  = '0;
                    out_cnt_next = '0;
                    elapsed_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (rate_wr) begin
            if (sel_reg) out_rate_next = rate_val;
            else         in_rate_next  = rate_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= 1'b0;
            idle_reg    <= 1'b0;
            elapsed_reg <= '0;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            vol_reg     <= '0;
            in_act_reg  <= 1'b0;
            out_act_reg <= 1'b0;
            window_reg  <= WINDOW_RST;
            in_cal_reg  <= CAL_RST;
            out_cal_reg <= CAL_RST;
            adv_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            idle_reg    <= idle_next;
            elapsed_reg <= elapsed_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            vol_reg     <= vol_next;
            in_act_reg  <= in_act_next;
            out_act_reg <= out_act_next;
            window_reg  <= window_next;
            in_cal_reg  <= in_cal_next;
            out_cal_reg <= out_cal_next;
            adv_en_reg  <= adv_en_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg      <= den_next;
        num_reg      <= num_next;
        in_rate_reg  <= in_rate_next;
        out_rate_reg <= out_rate_next;
        x_reg        <= x_next;
        step_reg     <= step_next;
        m_data_reg   <= m_data_next;
    end

    a_close_needs_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.close_fill_valve || m_data_reg.in_rate > RATE_ONE))
        else $error("fill valve closed without inflow above one");

    a_advance_needs_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.advance_regimen) |-> m_data_reg.close_fill_valve)
        else $error("regimen advance without valve close");

    a_save_low_rates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.save_volume) |->
        (m_data_reg.in_rate <= RATE_LOW_MAX && m_data_reg.out_rate <= RATE_LOW_MAX))
        else $error("volume save with flow still present");

    a_div_wait_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && !div_rsp.done) |-> div_rsp.busy)
        else $error("sequencer waits on an idle divider");

    a_counts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && state_next == ST_IDLE) |=>
        (elapsed_reg == '0 && in_cnt_reg == '0 && out_cnt_reg == '0))
        else $error("window counters not cleared after evaluation");

endmodule

// ----- hw/rtl/fprvt_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by both rate channels.
module fprvt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  fprvt_pkg::div_req_t req,
    output fprvt_pkg::div_rsp_t rsp
);
    import fprvt_pkg::*;

    localparam int STEP_CW = $clog2(DIV_Q_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_CW-1:0]   step_reg, step_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   div_reg, div_next;
    logic [DIV_Q_W-1:0]   q_reg, q_next;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    // remainder starts below the divisor, so the doubled value fits 33 bits
    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = req.rem_init;
            div_next  = req.divisor;
            q_next    = '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DIV_D_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[DIV_D_W-1:0];
            end
            q_next    = {q_reg[DIV_Q_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_CW'(DIV_Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.start && busy_reg) |=> busy_reg || done_reg)
        else $error("divider lost a running division");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !$past(req.start && !busy_reg)) |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

endmodule

// ----- verif/flow_tracker_scoreboard.sv -----
// Scoreboard for the flow pulse rate and volume tracker: predicts each report and checks it.
`timescale 1ns / 100ps

module flow_tracker_scoreboard #(
    parameter int COUNT_W = fprvt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  fprvt_pkg::in_item_t             s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  fprvt_pkg::out_item_t            m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [fprvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    output int unsigned                     reports_due,
    output int unsigned                     mismatches
);
    import fprvt_pkg::*;

    localparam logic [15:0] RATE_UNITY    = 16'd256;
    localparam logic [15:0] RATE_IDLE_MAX = 16'd6;   // rate * 40 < 256
    localparam logic [15:0] MS_SAT        = 16'hFFFF;
    localparam logic [31:0] VOL_FULL      = 32'hFFFF_FFFF;

    // configuration copy
    logic [15:0] win_len;
    logic [15:0] in_cal;
    logic [15:0] out_cal;
    logic        adv_en;

    // tracker state copy
    logic [15:0]        ms_count;
    logic [COUNT_W-1:0] in_count;
    logic [COUNT_W-1:0] out_count;
    logic [31:0]        res_vol;
    logic               filling;
    logic               draining;

    out_item_t   report_q[$];
    int unsigned err_cnt = 0;

    assign mismatches = err_cnt;

    function automatic logic [15:0] flow_rate(input logic [COUNT_W-1:0] cnt,
                                              input logic [15:0] ms,
                                              input logic [15:0] cal);
        logic [63:0] den;
        logic [63:0] quo;
        den = 64'(ms) * 64'(cal);
        if (den == 64'd0) begin
            return (cnt != '0) ? 16'hFFFF : 16'h0000;
        end
        quo = (64'(cnt) * 64'd65536000) / den;
        return (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
    endfunction

    function automatic logic [31:0] vol_step(input logic [15:0] rate);
        return 32'((64'(rate) * 64'd1000) / 64'd60);
    endfunction

    task automatic apply_request(input in_item_t r);
        logic [15:0] ir;
        logic [15:0] orate;
        logic [31:0] st;
        out_item_t   rpt;
        case (r.cmd)
            CMD_IN_PULSE: begin
                if (in_count != '1) in_count++;
            end
            CMD_OUT_PULSE: begin
                if (out_count != '1) out_count++;
            end
            CMD_LOAD: begin
                res_vol = r.volume_value;
            end
            default: begin
                if (ms_count != MS_SAT) ms_count++;
                if (ms_count > win_len) begin
                    ir    = flow_rate(in_count, ms_count, in_cal);
                    orate = flow_rate(out_count, ms_count, out_cal);
                    rpt   = '0;
                    rpt.in_rate  = ir;
                    rpt.out_rate = orate;
                    if (r.menu_idle) begin
                        if (ir > RATE_UNITY) begin
                            st = vol_step(ir);
                            res_vol = (res_vol > VOL_FULL - st) ? VOL_FULL : res_vol + st;
                            filling = 1'b1;
                            rpt.close_fill_valve = 1'b1;
                            rpt.advance_regimen  = adv_en;
                        end
                        if (orate > RATE_UNITY) begin
                            st = vol_step(orate);
                            res_vol = (res_vol > st) ? res_vol - st : 32'd0;
                            draining = 1'b1;
                        end
                        // irrigation over: both flows died down after activity
                        if ((filling || draining) && ir <= RATE_IDLE_MAX
                                && orate <= RATE_IDLE_MAX) begin
                            filling  = 1'b0;
                            draining = 1'b0;
                            rpt.save_volume = 1'b1;
                        end
                    end
                    rpt.volume = res_vol;
                    in_count  = '0;
                    out_count = '0;
                    ms_count  = '0;
                    report_q.push_back(rpt);
                end
            end
        endcase
    endtask

    task automatic check_report(input out_item_t got);
        out_item_t want;
        if (report_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("%0t: unexpected report in_rate %0d out_rate %0d volume %0d",
                         $realtime, got.in_rate, got.out_rate, got.volume);
            return;
        end
        want = report_q.pop_front();
        if (got.in_rate !== want.in_rate || got.out_rate !== want.out_rate
                || got.volume !== want.volume
                || got.close_fill_valve !== want.close_fill_valve
                || got.advance_regimen !== want.advance_regimen
                || got.save_volume !== want.save_volume) begin
            err_cnt++;
            if (err_cnt <= 10) begin
                $write("%0t: report mismatch (exp/got) in_rate %0d/%0d out_rate %0d/%0d",
                       $realtime, want.in_rate, got.in_rate, want.out_rate, got.out_rate);
                $display(" volume %0d/%0d close %b/%b advance %b/%b save %b/%b",
                         want.volume, got.volume, want.close_fill_valve, got.close_fill_valve,
                         want.advance_regimen, got.advance_regimen,
                         want.save_volume, got.save_volume);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_len   = WINDOW_RST;
            in_cal    = CAL_RST;
            out_cal   = CAL_RST;
            adv_en    = 1'b0;
            ms_count  = '0;
            in_count  = '0;
            out_count = '0;
            res_vol   = '0;
            filling   = 1'b0;
            draining  = 1'b0;
            report_q.delete();
        end else begin
            if (m_valid && m_ready) check_report(m_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WINDOW:  win_len = cfg_data;
                    REG_IN_CAL:  in_cal  = cfg_data;
                    REG_OUT_CAL: out_cal = cfg_data;
                    REG_ADVANCE: adv_en  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) apply_request(s_data);
        end
        reports_due <= report_q.size();
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the flow pulse rate and volume tracker: stimulus, clock, reset, verdict.
`timescale 1ns / 100ps

module tb;
    import fprvt_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int          SETTLE_CYCLES = 64;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    int unsigned reports_due;
    int unsigned mismatches;
    int unsigned cycle_cnt = 0;
    logic        no_gaps = 1'b0;

    flow_pulse_rate_volume_tracker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    flow_tracker_scoreboard sb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .reports_due (reports_due),
        .mismatches  (mismatches)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // report side: random stall per report, ready kept high when no stall is drawn
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            do @(posedge aclk); while (!(m_valid && m_ready));
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (stall - 1) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_req(input logic [1:0] cmd, input logic idle, input logic [31:0] vol);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.cmd          <= cmd;
        s_data.menu_idle    <= idle;
        s_data.volume_value <= vol;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_reports(input int tail);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // only called with the tracker drained
    task automatic set_config(input logic [15:0] win, input logic [15:0] ical,
                              input logic [15:0] ocal, input logic adv);
        put_reg(REG_WINDOW, win);
        put_reg(REG_IN_CAL, ical);
        put_reg(REG_OUT_CAL, ocal);
        put_reg(REG_ADVANCE, {15'd0, adv});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_cal();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom_range(256, 4096));
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int          ph;
        int          sel;
        int          mode;
        int          p_in;
        int          p_out;
        int          p_load;
        logic [1:0]  cmd;
        logic [31:0] vol;
        logic [15:0] win;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WINDOW;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: one full default window
        no_gaps = 1'b1;
        repeat (3) push_req(CMD_IN_PULSE, 1'b1, $urandom());
        repeat (2) push_req(CMD_OUT_PULSE, 1'b1, $urandom());
        repeat (1001) push_req(CMD_TICK, 1'b1, $urandom());
        drain_reports(SETTLE_CYCLES);

        // zero window, zero inflow calibration, advance on
        no_gaps = 1'b0;
        set_config(16'd0, 16'd0, 16'hFFFF, 1'b1);
        push_req(CMD_IN_PULSE, 1'b1, $urandom());
        push_req(CMD_TICK, 1'b1, $urandom());
        push_req(CMD_TICK, 1'b1, $urandom());          // flows stop: save
        push_req(CMD_TICK, 1'b1, $urandom());
        push_req(CMD_LOAD, 1'b0, 32'hFFFF_FFF0);
        push_req(CMD_IN_PULSE, 1'b1, $urandom());
        push_req(CMD_TICK, 1'b1, $urandom());          // volume saturates high
        push_req(CMD_LOAD, 1'b1, 32'd5);
        push_req(CMD_OUT_PULSE, 1'b1, $urandom());
        push_req(CMD_TICK, 1'b1, $urandom());          // volume floors at zero
        push_req(CMD_IN_PULSE, 1'b0, $urandom());
        push_req(CMD_OUT_PULSE, 1'b0, $urandom());
        push_req(CMD_TICK, 1'b0, $urandom());          // menu open
        push_req(CMD_TICK, 1'b1, $urandom());
        push_req(CMD_LOAD, 1'b1, 32'd0);
        push_req(CMD_LOAD, 1'b0, 32'hFFFF_FFFF);
        push_req(CMD_TICK, 1'b1, 32'd0);
        drain_reports(SETTLE_CYCLES);

        // rate exactly one unit on outflow, twice that on inflow
        set_config(16'd3, 16'd64000, 16'd64000, 1'b0);
        repeat (2) push_req(CMD_IN_PULSE, 1'b1, $urandom());
        push_req(CMD_OUT_PULSE, 1'b1, $urandom());
        repeat (4) push_req(CMD_TICK, 1'b1, $urandom());
        drain_reports(SETTLE_CYCLES);

        // inflow rate right at the low threshold ends irrigation
        no_gaps = 1'b1;
        set_config(16'd159, 16'hFFFF, 16'hFFFF, 1'b0);
        push_req(CMD_IN_PULSE, 1'b1, $urandom());
        repeat (160) push_req(CMD_TICK, 1'b1, $urandom());
        drain_reports(SETTLE_CYCLES);

        // window that never closes: counts carry over into the next setting
        set_config(16'hFFFF, 16'd1, 16'hFFFF, 1'b0);
        repeat (10) begin
            push_req(CMD_IN_PULSE, 1'($urandom_range(0, 1)), $urandom());
            push_req(CMD_OUT_PULSE, 1'($urandom_range(0, 1)), $urandom());
            push_req(CMD_TICK, 1'($urandom_range(0, 1)), $urandom());
        end
        drain_reports(SETTLE_CYCLES);
        set_config(16'd0, 16'd1, 16'hFFFF, 1'b1);
        push_req(CMD_TICK, 1'b1, $urandom());
        drain_reports(SETTLE_CYCLES);

        // random phases, each under its own register setting
        for (ph = 0; ph < 8; ph++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 19);
            if (sel < 5)       win = 16'd0;
            else if (sel < 12) win = 16'($urandom_range(1, 8));
            else if (sel < 17) win = 16'($urandom_range(9, 40));
            else               win = 16'($urandom_range(100, 300));
            set_config(win, pick_cal(), pick_cal(), 1'($urandom_range(0, 1)));
            mode = $urandom_range(0, 3);
            repeat (100) begin
                if ($urandom_range(0, 15) == 0) mode = $urandom_range(0, 3);
                if ($urandom_range(0, 199) == 0) drain_reports(0);
                // quiet, filling, draining or mixed flow
                case (mode)
                    0:       begin p_in = 3;  p_out = 2;  p_load = 5; end
                    1:       begin p_in = 60; p_out = 2;  p_load = 3; end
                    2:       begin p_in = 2;  p_out = 60; p_load = 3; end
                    default: begin p_in = 32; p_out = 32; p_load = 6; end
                endcase
                sel = $urandom_range(0, 99);
                if (sel < p_in)                       cmd = CMD_IN_PULSE;
                else if (sel < p_in + p_out)          cmd = CMD_OUT_PULSE;
                else if (sel < p_in + p_out + p_load) cmd = CMD_LOAD;
                else                                  cmd = CMD_TICK;
                vol = $urandom();
                if (cmd == CMD_LOAD) begin
                    case ($urandom_range(0, 2))
                        0:       vol = $urandom();
                        1:       vol = 32'hFFFF_FFFF - $urandom_range(0, 2000000);
                        default: vol = $urandom_range(0, 2000000);
                    endcase
                end
                push_req(cmd, ($urandom_range(0, 4) != 0), vol);
            end
            drain_reports(SETTLE_CYCLES);
        end

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- flow_pulse_rate_volume_tracker_core.f -----
hw/rtl/fprvt_pkg.sv
hw/rtl/fprvt_div.sv
hw/rtl/flow_pulse_rate_volume_tracker_core.sv
verif/flow_tracker_scoreboard.sv
verif/tb.sv
